### hdl/htb_pkg.sv
// Shared types and constants for the Huffman tree builder.
`timescale 1ns / 1ps
`default_nettype none
package htb_pkg;

  localparam int DEF_MAX_LEAVES  = 64;
  localparam int DEF_WEIGHT_BITS = 24;

  localparam int SYM_W    = 8;
  localparam int PARENT_W = 6;

  // Input operation codes (in_tuser)
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  // Result kinds (out_tuser)
  typedef enum logic [1:0] {
    KIND_ADD_OK    = 2'd0,
    KIND_ADD_FULL  = 2'd1,
    KIND_MERGE     = 2'd2,
    KIND_BUILD_LOW = 2'd3
  } kind_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic clear;   // drop all entries
    logic shift;   // push new entry in at the front
    logic hit;     // re-place the matching entry with a raised weight
    logic merge;   // pop two front entries, place the parent
  } cell_cmd_t;

endpackage
`default_nettype wire

### hdl/huffman_tree_builder.sv
// Top level of the Huffman tree builder: control, cell chain and result register.
//
// Input beats: in_tuser selects the operation (0 add, 1 build), in_tdata
// carries the byte symbol. Result beats: out_tuser carries the kind, out_tdata
// the merge record fields, out_tlast marks the final result of an input beat.
// An add beat is handled in the cycle it is accepted; its single status
// result is valid on the next cycle. A new beat can be taken every cycle
// while adds are flowing and the receiver keeps up.
// A build beat with n entries emits n-1 merge records, one per cycle while
// the receiver keeps up; in_tready stays low until the last record is loaded.
// Each merge but the last is one merge step of the cell chain; the last
// clears it.
// A build with fewer than two entries answers one result and empties the list.
// With a result pending and out_tready low the result register holds and the
// chain stops; no beat is taken and no merge advances until it is taken.
// Reset empties the list and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_builder #(
  parameter int MAX_LEAVES  = htb_pkg::DEF_MAX_LEAVES,
  parameter int WEIGHT_BITS = htb_pkg::DEF_WEIGHT_BITS,
  localparam int OUT_DW = ((2 * htb_pkg::SYM_W + 2 + htb_pkg::PARENT_W + WEIGHT_BITS + 7) / 8) * 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire [htb_pkg::SYM_W-1:0]    in_tdata,   // [7:0] symbol
  input  wire                         in_tuser,   // [0] operation
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [OUT_DW-1:0]           out_tdata,  // left_is_leaf, left_id, right_is_leaf,
                                                  // right_id, parent_id, merged_weight
  output logic [1:0]                  out_tuser,  // [1:0] kind
  output logic                        out_tlast
);

  localparam int CNT_W = $clog2(MAX_LEAVES + 1);
  localparam int SYM_W = htb_pkg::SYM_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BUILD = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SYM_W-1:0]   nint_r, nint_nxt;

  logic                    out_valid_r, out_valid_nxt;
  htb_pkg::kind_t          out_kind_r, out_kind_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    o_lleaf_r, o_lleaf_nxt, o_rleaf_r, o_rleaf_nxt;
  logic [SYM_W-1:0]        o_lid_r, o_lid_nxt, o_rid_r, o_rid_nxt;
  logic [htb_pkg::PARENT_W-1:0] o_pid_r, o_pid_nxt;
  logic [WEIGHT_BITS-1:0]  o_w_r, o_w_nxt;

  // chain taps, two spare slots past the end read as empty
  logic                   cv  [0:MAX_LEAVES+1];
  logic                   cl  [0:MAX_LEAVES+1];
  logic [SYM_W-1:0]       cid [0:MAX_LEAVES+1];
  logic [WEIGHT_BITS-1:0] cw  [0:MAX_LEAVES+1];
  logic                   aft [0:MAX_LEAVES];
  logic [MAX_LEAVES-1:0]  match;

  htb_pkg::cell_cmd_t     cmd;
  logic                   ins_leaf;
  logic [SYM_W-1:0]       ins_id;
  logic [WEIGHT_BITS-1:0] ins_w;

  logic                   out_free, in_acc, any_hit, step;
  logic [WEIGHT_BITS-1:0] hit_w, inc_w, sum_w;
  logic [WEIGHT_BITS:0]   inc_x, sum_x;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign step      = (state_r == ST_BUILD) && out_free;

  // weight of the matching entry (at most one leaf per symbol)
  always_comb begin
    hit_w = '0;
    for (int k = 0; k < MAX_LEAVES; k++) begin
      hit_w = hit_w | (match[k] ? cw[k] : '0);
    end
  end
  assign any_hit = |match;

  // saturating count increment and merge sum
  assign inc_x = {1'b0, hit_w} + {{WEIGHT_BITS{1'b0}}, 1'b1};
  assign inc_w = inc_x[WEIGHT_BITS] ? '1 : inc_x[WEIGHT_BITS-1:0];
  assign sum_x = {1'b0, cw[0]} + {1'b0, cw[1]};
  assign sum_w = sum_x[WEIGHT_BITS] ? '1 : sum_x[WEIGHT_BITS-1:0];

  // control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    nint_nxt      = nint_r;
    cmd           = '0;
    ins_leaf      = 1'b1;
    ins_id        = in_tdata;
    ins_w         = {{(WEIGHT_BITS-1){1'b0}}, 1'b1};
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    o_lleaf_nxt   = o_lleaf_r;
    o_lid_nxt     = o_lid_r;
    o_rleaf_nxt   = o_rleaf_r;
    o_rid_nxt     = o_rid_r;
    o_pid_nxt     = o_pid_r;
    o_w_nxt       = o_w_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          o_lleaf_nxt   = 1'b0;
          o_lid_nxt     = '0;
          o_rleaf_nxt   = 1'b0;
          o_rid_nxt     = '0;
          o_pid_nxt     = '0;
          o_w_nxt       = '0;
          if (in_tuser == htb_pkg::OP_ADD) begin
            out_kind_nxt = htb_pkg::KIND_ADD_OK;
            if (any_hit) begin
              cmd.hit = 1'b1;
              ins_w   = inc_w;
            end else if (count_r == CNT_W'(MAX_LEAVES)) begin
              out_kind_nxt = htb_pkg::KIND_ADD_FULL;
            end else begin
              cmd.shift = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r < CNT_W'(2)) begin
            out_kind_nxt = htb_pkg::KIND_BUILD_LOW;
            cmd.clear    = 1'b1;
            count_nxt    = '0;
          end else begin
            out_valid_nxt = 1'b0;
            nint_nxt      = '0;
            state_nxt     = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        if (step) begin
          ins_leaf      = 1'b0;
          ins_id        = nint_r;
          ins_w         = sum_w;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = htb_pkg::KIND_MERGE;
          o_lleaf_nxt   = cl[0];
          o_lid_nxt     = cid[0];
          o_rleaf_nxt   = cl[1];
          o_rid_nxt     = cid[1];
          o_pid_nxt     = nint_r[htb_pkg::PARENT_W-1:0];
          o_w_nxt       = sum_w;
          nint_nxt      = nint_r + 1'b1;
          if (count_r == CNT_W'(2)) begin
            out_last_nxt = 1'b1;
            cmd.clear    = 1'b1;
            count_nxt    = '0;
            nint_nxt     = '0;
            state_nxt    = ST_IDLE;
          end else begin
            out_last_nxt = 1'b0;
            cmd.merge    = 1'b1;
            count_nxt    = count_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      nint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      nint_r      <= nint_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    o_lleaf_r  <= o_lleaf_nxt;
    o_lid_r    <= o_lid_nxt;
    o_rleaf_r  <= o_rleaf_nxt;
    o_rid_r    <= o_rid_nxt;
    o_pid_r    <= o_pid_nxt;
    o_w_r      <= o_w_nxt;
  end

  // cell chain
  assign aft[0] = 1'b0;
  for (genvar k = MAX_LEAVES; k < MAX_LEAVES + 2; k++) begin : g_tail
    assign cv[k]  = 1'b0;
    assign cl[k]  = 1'b0;
    assign cid[k] = '0;
    assign cw[k]  = '0;
  end

  for (genvar k = 0; k < MAX_LEAVES; k++) begin : g_cell
    logic                   pv, pl;
    logic [SYM_W-1:0]       pid;
    logic [WEIGHT_BITS-1:0] pw;
    if (k == 0) begin : g_front
      assign pv  = 1'b1;
      assign pl  = ins_leaf;
      assign pid = ins_id;
      assign pw  = ins_w;
    end else begin : g_inner
      assign pv  = cv[k-1];
      assign pl  = cl[k-1];
      assign pid = cid[k-1];
      assign pw  = cw[k-1];
    end
    htb_cell #(.WEIGHT_BITS(WEIGHT_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .head_i   (k == 0),
      .aft_i    (aft[k]),
      .aft_o    (aft[k+1]),
      .match_o  (match[k]),
      .ins_leaf (ins_leaf),
      .ins_id   (ins_id),
      .ins_w    (ins_w),
      .prev_v   (pv),
      .prev_l   (pl),
      .prev_id  (pid),
      .prev_w   (pw),
      .n1_v     (cv[k+1]),
      .n1_l     (cl[k+1]),
      .n1_id    (cid[k+1]),
      .n1_w     (cw[k+1]),
      .n2_v     (cv[k+2]),
      .n2_l     (cl[k+2]),
      .n2_id    (cid[k+2]),
      .n2_w     (cw[k+2]),
      .v_o      (cv[k]),
      .l_o      (cl[k]),
      .id_o     (cid[k]),
      .w_o      (cw[k])
    );
  end

  // result beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DW'({o_w_r, o_pid_r, o_rid_r, o_rleaf_r, o_lid_r, o_lleaf_r});

  // checks
  a_build_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUILD) |-> (count_r >= CNT_W'(2)))
    else $error("build running with fewer than two entries");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_LEAVES))
    else $error("entry count beyond list size");

  a_last_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (count_r == CNT_W'(2))) |=> (state_r == ST_IDLE) && out_tlast && (count_r == '0))
    else $error("final merge did not close the build");

  a_no_take_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUILD) |-> !in_tready)
    else $error("input taken during build");

endmodule
`default_nettype wire

### hdl/htb_cell.sv
// One slot of the sorted entry chain: holds one weighted node.
`timescale 1ns / 1ps
`default_nettype none
module htb_cell #(
  parameter int WEIGHT_BITS = htb_pkg::DEF_WEIGHT_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  htb_pkg::cell_cmd_t            cmd,
  input  wire                           head_i,   // tied high in the front cell
  input  wire                           aft_i,    // a matching entry lies ahead of this cell
  output logic                          aft_o,
  output logic                          match_o,
  // broadcast entry and sort key
  input  wire                           ins_leaf,
  input  wire [htb_pkg::SYM_W-1:0]      ins_id,
  input  wire [WEIGHT_BITS-1:0]         ins_w,
  // neighbor toward the front
  input  wire                           prev_v,
  input  wire                           prev_l,
  input  wire [htb_pkg::SYM_W-1:0]      prev_id,
  input  wire [WEIGHT_BITS-1:0]         prev_w,
  // neighbors toward the back
  input  wire                           n1_v,
  input  wire                           n1_l,
  input  wire [htb_pkg::SYM_W-1:0]      n1_id,
  input  wire [WEIGHT_BITS-1:0]         n1_w,
  input  wire                           n2_v,
  input  wire                           n2_l,
  input  wire [htb_pkg::SYM_W-1:0]      n2_id,
  input  wire [WEIGHT_BITS-1:0]         n2_w,
  // own contents
  output logic                          v_o,
  output logic                          l_o,
  output logic [htb_pkg::SYM_W-1:0]     id_o,
  output logic [WEIGHT_BITS-1:0]        w_o
);

  logic                      v_r, v_nxt;
  logic                      l_r, l_nxt;
  logic [htb_pkg::SYM_W-1:0] id_r, id_nxt;
  logic [WEIGHT_BITS-1:0]    w_r, w_nxt;
  logic                      n1_lt, n2_lt;

  assign match_o = v_r && l_r && (id_r == ins_id);
  assign aft_o   = aft_i | match_o;
  assign n1_lt   = n1_v && (n1_w < ins_w);
  assign n2_lt   = n2_v && (n2_w < ins_w);

  // slot update
  always_comb begin
    v_nxt  = v_r;
    l_nxt  = l_r;
    id_nxt = id_r;
    w_nxt  = w_r;
    priority if (cmd.clear) begin
      v_nxt = 1'b0;
    end else if (cmd.shift) begin
      v_nxt = prev_v; l_nxt = prev_l; id_nxt = prev_id; w_nxt = prev_w;
    end else if (cmd.hit) begin
      // entries behind the hit with smaller weight move up one slot
      if (aft_o && n1_lt) begin
        v_nxt = n1_v; l_nxt = n1_l; id_nxt = n1_id; w_nxt = n1_w;
      end else if (aft_o && (match_o || (v_r && (w_r < ins_w)))) begin
        v_nxt = 1'b1; l_nxt = ins_leaf; id_nxt = ins_id; w_nxt = ins_w;
      end
    end else if (cmd.merge) begin
      // list shifts up by two, parent lands behind all smaller weights
      if (n2_lt) begin
        v_nxt = n2_v; l_nxt = n2_l; id_nxt = n2_id; w_nxt = n2_w;
      end else if (head_i || n1_lt) begin
        v_nxt = 1'b1; l_nxt = ins_leaf; id_nxt = ins_id; w_nxt = ins_w;
      end else begin
        v_nxt = n1_v; l_nxt = n1_l; id_nxt = n1_id; w_nxt = n1_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    l_r  <= l_nxt;
    id_r <= id_nxt;
    w_r  <= w_nxt;
  end

  assign v_o  = v_r;
  assign l_o  = l_r;
  assign id_o = id_r;
  assign w_o  = w_r;

endmodule
`default_nettype wire
